// ----- sv/hid_pkg.sv -----
// ----------------------------------------------------------------------------
// hid_pkg
// Shared constants, types and Hilbert tables for the 2-D curve key block.
// ----------------------------------------------------------------------------
package hid_pkg;

    localparam int LEVELS      = 14;
    localparam int CELL_W      = LEVELS;
    localparam int CELL_MAX    = (1 << LEVELS) - 1;
    localparam int COORD_W     = 32;
    localparam int GAIN_W      = 32;
    localparam int PROD_W      = 2 * GAIN_W;
    localparam int TAG_W       = 24;
    localparam int CURVE_KEY_W = 28;
    localparam int KEY_EXT_W   = (2 * LEVELS > CURVE_KEY_W) ? 2 * LEVELS : CURVE_KEY_W;
    localparam int WALK_STEP   = 7;
    localparam int WALK_STAGES = (LEVELS + WALK_STEP - 1) / WALK_STEP;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_X_GAIN   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_Y_GAIN   = CFG_IDX_W'(3);

    typedef enum logic [1:0] {
        ST_A = 2'd0,
        ST_D = 2'd1,
        ST_C = 2'd2,
        ST_U = 2'd3
    } t_hstate;

    // indexed by {state, quadrant}, quadrant = {xbit, ybit}
    localparam logic [1:0] DIGIT_TAB [16] = '{
        2'd0, 2'd1, 2'd3, 2'd2,
        2'd0, 2'd3, 2'd1, 2'd2,
        2'd2, 2'd1, 2'd3, 2'd0,
        2'd2, 2'd3, 2'd1, 2'd0
    };

    localparam t_hstate NEXT_TAB [16] = '{
        ST_D, ST_A, ST_C, ST_A,
        ST_A, ST_U, ST_D, ST_D,
        ST_C, ST_C, ST_A, ST_U,
        ST_U, ST_D, ST_U, ST_C
    };

    typedef struct packed {
        logic [COORD_W-1:0] x_origin;
        logic [COORD_W-1:0] y_origin;
        logic [GAIN_W-1:0]  x_gain;
        logic [GAIN_W-1:0]  y_gain;
    } t_cfg;

    typedef struct packed {
        logic [CELL_W-1:0] x_cell;
        logic [CELL_W-1:0] y_cell;
        logic [TAG_W-1:0]  tag;
    } t_cell_item;

endpackage

// ----- sv/hid_cfg.sv -----
// ----------------------------------------------------------------------------
// hid_cfg
// Configuration register file: bounding box origin and gain per axis.
// ----------------------------------------------------------------------------
module hid_cfg
    import hid_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_X_ORIGIN: r_cfg.x_origin <= i_cfg_data;
                CFG_Y_ORIGIN: r_cfg.y_origin <= i_cfg_data;
                CFG_X_GAIN:   r_cfg.x_gain   <= i_cfg_data;
                CFG_Y_GAIN:   r_cfg.y_gain   <= i_cfg_data;
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

endmodule

// ----- sv/hid_scale.sv -----
// ----------------------------------------------------------------------------
// hid_scale
// Three-stage coordinate to cell scaling: offset, multiply, clamp.
// ----------------------------------------------------------------------------
module hid_scale
    import hid_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [COORD_W-1:0] i_x_coord,
    input  logic [COORD_W-1:0] i_y_coord,
    input  logic [TAG_W-1:0]   i_point_tag,
    output logic               o_valid,
    input  logic               i_stall,
    output t_cell_item         o_item
);

    logic [2:0] r_v;
    logic [3:0] w_en;

    // stage 1: offset
    logic [COORD_W:0]   n_dx;
    logic [COORD_W:0]   n_dy;
    logic               r_dx_pos;
    logic               r_dy_pos;
    logic [COORD_W-1:0] r_dx_mag;
    logic [COORD_W-1:0] r_dy_mag;
    logic [TAG_W-1:0]   r_tag1;

    // stage 2: product
    logic [PROD_W-1:0]  w_prod_x;
    logic [PROD_W-1:0]  w_prod_y;
    logic [GAIN_W-1:0]  r_px_hi;
    logic [GAIN_W-1:0]  r_py_hi;
    logic [TAG_W-1:0]   r_tag2;

    // stage 3: clamp
    logic [CELL_W-1:0]  n_x_cell;
    logic [CELL_W-1:0]  n_y_cell;
    t_cell_item         r_item;

    assign w_en[3] = !i_stall;
    assign w_en[2] = !r_v[2] || w_en[3];
    assign w_en[1] = !r_v[1] || w_en[2];
    assign w_en[0] = !r_v[0] || w_en[1];

    assign o_stall = !w_en[0];
    assign o_valid = r_v[2];
    assign o_item  = r_item;

    assign n_dx = {i_x_coord[COORD_W-1], i_x_coord}
                - {i_cfg.x_origin[COORD_W-1], i_cfg.x_origin};
    assign n_dy = {i_y_coord[COORD_W-1], i_y_coord}
                - {i_cfg.y_origin[COORD_W-1], i_cfg.y_origin};

    assign w_prod_x = PROD_W'(r_dx_mag) * PROD_W'(i_cfg.x_gain);
    assign w_prod_y = PROD_W'(r_dy_mag) * PROD_W'(i_cfg.y_gain);

    assign n_x_cell = (r_px_hi > GAIN_W'(CELL_MAX)) ? CELL_W'(CELL_MAX)
                                                    : r_px_hi[CELL_W-1:0];
    assign n_y_cell = (r_py_hi > GAIN_W'(CELL_MAX)) ? CELL_W'(CELL_MAX)
                                                    : r_py_hi[CELL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            if (w_en[1]) r_v[1] <= r_v[0];
            if (w_en[2]) r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            // non-positive offset maps to cell 0
            r_dx_pos <= !n_dx[COORD_W] && (n_dx != '0);
            r_dy_pos <= !n_dy[COORD_W] && (n_dy != '0);
            r_dx_mag <= n_dx[COORD_W-1:0];
            r_dy_mag <= n_dy[COORD_W-1:0];
            r_tag1   <= i_point_tag;
        end
        if (w_en[1]) begin
            r_px_hi <= r_dx_pos ? w_prod_x[PROD_W-1:GAIN_W] : '0;
            r_py_hi <= r_dy_pos ? w_prod_y[PROD_W-1:GAIN_W] : '0;
            r_tag2  <= r_tag1;
        end
        if (w_en[2]) begin
            r_item.x_cell <= n_x_cell;
            r_item.y_cell <= n_y_cell;
            r_item.tag    <= r_tag2;
        end
    end

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v == 3'b111) && i_stall)
        else $error("scale pipe stalls upstream with a free stage");

    a_bubble_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[1] && w_en[0] && i_valid |=> r_v[0])
        else $error("accepted transaction lost in scale stage 1");

endmodule

// ----- sv/hid_walk.sv -----
// ----------------------------------------------------------------------------
// hid_walk
// Pipelined Hilbert automaton walk, WALK_STEP levels per register stage.
// ----------------------------------------------------------------------------
module hid_walk
    import hid_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  t_cell_item             i_item,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [CURVE_KEY_W-1:0] o_curve_key,
    output logic [TAG_W-1:0]       o_tag_out
);

    logic [WALK_STAGES:0]   w_en;
    logic [WALK_STAGES-1:0] r_v;
    logic [WALK_STAGES-1:0] w_src_v;

    t_hstate              w_src_st [WALK_STAGES];
    logic [KEY_EXT_W-1:0] w_src_key [WALK_STAGES];
    logic [CELL_W-1:0]    w_src_cx [WALK_STAGES];
    logic [CELL_W-1:0]    w_src_cy [WALK_STAGES];
    logic [TAG_W-1:0]     w_src_tag [WALK_STAGES];

    t_hstate              n_st [WALK_STAGES];
    logic [KEY_EXT_W-1:0] n_key [WALK_STAGES];
    logic [CELL_W-1:0]    n_cx [WALK_STAGES];
    logic [CELL_W-1:0]    n_cy [WALK_STAGES];

    t_hstate              r_st [WALK_STAGES];
    logic [KEY_EXT_W-1:0] r_key [WALK_STAGES];
    logic [CELL_W-1:0]    r_cx [WALK_STAGES];
    logic [CELL_W-1:0]    r_cy [WALK_STAGES];
    logic [TAG_W-1:0]     r_tag [WALK_STAGES];

    assign w_en[WALK_STAGES] = !i_stall;
    assign o_stall           = !w_en[0];
    assign o_valid           = r_v[WALK_STAGES-1];
    assign o_curve_key       = r_key[WALK_STAGES-1][CURVE_KEY_W-1:0];
    assign o_tag_out         = r_tag[WALK_STAGES-1];

    for (genvar s = 0; s < WALK_STAGES; s++) begin : g_stage
        assign w_en[s] = !r_v[s] || w_en[s+1];

        if (s == 0) begin : g_head
            assign w_src_v[s]   = i_valid;
            assign w_src_st[s]  = ST_A;
            assign w_src_key[s] = '0;
            assign w_src_cx[s]  = i_item.x_cell;
            assign w_src_cy[s]  = i_item.y_cell;
            assign w_src_tag[s] = i_item.tag;
        end else begin : g_body
            assign w_src_v[s]   = r_v[s-1];
            assign w_src_st[s]  = r_st[s-1];
            assign w_src_key[s] = r_key[s-1];
            assign w_src_cx[s]  = r_cx[s-1];
            assign w_src_cy[s]  = r_cy[s-1];
            assign w_src_tag[s] = r_tag[s-1];
        end

        // cells shift left so the current level always sits in the top bit
        always_comb begin
            logic [3:0] ix;
            n_st[s]  = w_src_st[s];
            n_key[s] = w_src_key[s];
            n_cx[s]  = w_src_cx[s];
            n_cy[s]  = w_src_cy[s];
            for (int j = 0; j < WALK_STEP; j++) begin
                if (s * WALK_STEP + j < LEVELS) begin
                    ix       = {n_st[s], n_cx[s][CELL_W-1], n_cy[s][CELL_W-1]};
                    n_key[s] = {n_key[s][KEY_EXT_W-3:0], DIGIT_TAB[ix]};
                    n_st[s]  = NEXT_TAB[ix];
                    n_cx[s]  = n_cx[s] << 1;
                    n_cy[s]  = n_cy[s] << 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (w_en[s]) begin
                r_v[s] <= w_src_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[s]) begin
                r_st[s]  <= n_st[s];
                r_key[s] <= n_key[s];
                r_cx[s]  <= n_cx[s];
                r_cy[s]  <= n_cy[s];
                r_tag[s] <= w_src_tag[s];
            end
        end
    end

    a_free_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("walk pipe stalls upstream while output is free");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall && (&r_v))
        else $error("walk pipe stalls upstream with a free stage");

endmodule

// ----- sv/hilbert_index_2d.sv -----
// ----------------------------------------------------------------------------
// hilbert_index_2d
// Streaming 2-D Hilbert curve key of a point inside a configured box.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall) carries x, y and a tag; a transaction
// completes on a clock edge with i_valid high and o_stall low. The output
// channel (o_valid / i_stall) returns the 28-bit key and the same tag, one
// result per point, in order.
// The pipeline stages are offset, 32x32 multiply, clamp, then the
// automaton walk at 7 levels per stage. One point is taken every cycle
// while o_stall is low; the datapath is fully pipelined.
// Each stage has its own valid bit, so bubbles close up while the receiver
// stalls; o_stall rises only when every stage holds a transaction.
// The configuration port (i_cfg_valid / o_cfg_ready, always ready) writes
// x_origin, y_origin, x_gain, y_gain at index 0..3; other indexes are
// ignored. Write only while the pipe is empty.
// Synchronous active-low reset clears all valid bits and zeroes the configuration registers.
// ----------------------------------------------------------------------------
module hilbert_index_2d
    import hid_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [COORD_W-1:0]     i_x_coord,
    input  logic [COORD_W-1:0]     i_y_coord,
    input  logic [TAG_W-1:0]       i_point_tag,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [CURVE_KEY_W-1:0] o_curve_key,
    output logic [TAG_W-1:0]       o_tag_out
);

    t_cfg       w_cfg;
    t_cell_item w_item;
    logic       w_item_valid;
    logic       w_item_stall;

    hid_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    hid_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_x_coord   (i_x_coord),
        .i_y_coord   (i_y_coord),
        .i_point_tag (i_point_tag),
        .o_valid     (w_item_valid),
        .i_stall     (w_item_stall),
        .o_item      (w_item)
    );

    hid_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_item_valid),
        .o_stall     (w_item_stall),
        .i_item      (w_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_curve_key (o_curve_key),
        .o_tag_out   (o_tag_out)
    );

endmodule
